[rtl/dgs_pkg.sv]
// Shared types and codes for the density grid smoothing block.
// No dependencies; used by dgs_ctrl, dgs_datapath and density_grid_smoothing_top.
package dgs_pkg;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	localparam int CFG_BITS = 7;

	localparam logic [2:0] PH_C = 3'd0;
	localparam logic [2:0] PH_U = 3'd1;
	localparam logic [2:0] PH_D = 3'd2;
	localparam logic [2:0] PH_L = 3'd3;
	localparam logic [2:0] PH_R = 3'd4;
	localparam logic [2:0] PH_W = 3'd5;

	typedef struct packed {
		logic       host_we;
		logic       pass_en;
		logic       copy_en;
		logic [2:0] phase;
		logic       sweep_clear;
		logic       sweep_next;
		logic       show_read;
	} dgs_ctl_t;

	typedef struct packed {
		logic bad;
		logic grid_ok;
		logic last_cell;
	} dgs_stat_t;

endpackage

[rtl/density_grid_smoothing_top.sv]
// Top level of the density grid smoothing block: controller plus datapath.
// Load and read: result strobe (done) in the cycle after start.
// Run: per pass, phases C, U, D, L, R, W for each cell (one density read port), then a
// copy-back of all cells; busy stays high meanwhile; result strobe after the last pass.
// done lasts one cycle and cannot be stalled. arst_n clears control state;
// grid memories are undefined until loaded. Depends on dgs_pkg, dgs_ctrl, dgs_datapath.
module density_grid_smoothing_top #(
	parameter int GRID_SIDE_MAX = 64,
	parameter int VALUE_BITS    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [11:0]                  cell_index,
	input  logic [31:0]                  cell_value,
	input  logic [7:0]                   pass_count,
	output logic                         done,
	output logic [31:0]                  read_value,
	output logic                         index_error,
	output logic                         run_done,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [dgs_pkg::CFG_BITS-1:0] cfg_data
);
	import dgs_pkg::*;

	dgs_ctl_t  ctl;
	dgs_stat_t stat;

	dgs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.pass_count  (pass_count),
		.stat        (stat),
		.ctl         (ctl),
		.busy        (busy),
		.done        (done),
		.index_error (index_error),
		.run_done    (run_done)
	);

	dgs_datapath #(
		.GRID_SIDE_MAX (GRID_SIDE_MAX),
		.VALUE_BITS    (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_index (cell_index),
		.cell_value (cell_value),
		.ctl        (ctl),
		.stat       (stat),
		.read_value (read_value)
	);
endmodule

[rtl/dgs_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module dgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/dgs_datapath.sv]
// Datapath: configuration registers, cell counters, stencil accumulator,
// density and scratch memories. Depends on dgs_pkg and dgs_ram.
module dgs_datapath #(
	parameter int GRID_SIDE_MAX = 64,
	parameter int VALUE_BITS    = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [dgs_pkg::CFG_BITS-1:0] cfg_data,
	input  logic [11:0]              cell_index,
	input  logic [31:0]              cell_value,
	input  dgs_pkg::dgs_ctl_t        ctl,
	output dgs_pkg::dgs_stat_t       stat,
	output logic [31:0]              read_value
);
	import dgs_pkg::*;

	localparam int CELLS = GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(GRID_SIDE_MAX + 1);
	localparam int ACCW  = VALUE_BITS + 3;

	logic [CFG_BITS-1:0]   grid_width_q, grid_height_q;
	logic [SW-1:0]         w, h, x_q, y_q;
	logic [2*SW-1:0]       n;
	logic [AW-1:0]         i_q, pass_addr, host_addr, wb_addr_s1;
	logic                  wb_s1, interior;
	logic [ACCW-1:0]       acc_q, acc_sum;
	logic [VALUE_BITS-1:0] center_q, dens_rdata, scr_rdata, dens_wdata, scr_wdata, host_wdata;
	logic                  dens_we;
	logic [AW-1:0]         dens_waddr, dens_raddr;
	logic [63:0]           cell_wide, read_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_BITS'(64);
			grid_height_q <= CFG_BITS'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w = (32'(grid_width_q) > GRID_SIDE_MAX) ? SW'(GRID_SIDE_MAX) : SW'(grid_width_q);
	assign h = (32'(grid_height_q) > GRID_SIDE_MAX) ? SW'(GRID_SIDE_MAX) : SW'(grid_height_q);
	assign n = (2*SW)'(w) * (2*SW)'(h);

	assign stat.bad       = (32'(cell_index) >= 32'(n)) || (32'(cell_index) >= CELLS);
	assign stat.grid_ok   = (w >= SW'(3)) && (h >= SW'(3));
	assign stat.last_cell = (32'(i_q) + 32'd1) == 32'(n);

	assign interior = (x_q != '0) && (32'(x_q) + 32'd2 <= 32'(w))
		&& (y_q != '0) && (32'(y_q) + 32'd2 <= 32'(h));

	// walk cells in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			i_q   <= '0;
			wb_s1 <= 1'b0;
		end else begin
			wb_s1 <= ctl.copy_en;
			if (ctl.sweep_clear) begin
				x_q <= '0;
				y_q <= '0;
				i_q <= '0;
			end else if (ctl.sweep_next) begin
				i_q <= i_q + AW'(1);
				if (x_q + SW'(1) == w) begin
					x_q <= '0;
					y_q <= y_q + SW'(1);
				end else begin
					x_q <= x_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= i_q;
	end

	always_comb begin
		case (ctl.phase)
			PH_U:    pass_addr = i_q - AW'(w);
			PH_D:    pass_addr = i_q + AW'(w);
			PH_L:    pass_addr = i_q - AW'(1);
			PH_R:    pass_addr = i_q + AW'(1);
			default: pass_addr = i_q;
		endcase
	end

	assign acc_sum = acc_q + ACCW'(dens_rdata);

	// accumulate 4*center + neighbors
	always_ff @(posedge clk) begin
		if (ctl.pass_en) begin
			if (ctl.phase == PH_U) begin
				center_q <= dens_rdata;
				acc_q    <= ACCW'(dens_rdata) << 2;
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	assign scr_wdata = interior ? VALUE_BITS'(acc_sum >> 3) : center_q;

	assign cell_wide  = 64'(cell_value);
	assign host_wdata = cell_wide[VALUE_BITS-1:0];
	assign host_addr  = AW'(32'(cell_index));

	assign dens_we    = ctl.host_we || wb_s1;
	assign dens_waddr = wb_s1 ? wb_addr_s1 : host_addr;
	assign dens_wdata = wb_s1 ? scr_rdata : host_wdata;
	assign dens_raddr = ctl.pass_en ? pass_addr : host_addr;

	dgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_density (
		.clk   (clk),
		.we    (dens_we),
		.waddr (dens_waddr),
		.wdata (dens_wdata),
		.raddr (dens_raddr),
		.rdata (dens_rdata)
	);

	dgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_scratch (
		.clk   (clk),
		.we    (ctl.pass_en && ctl.phase == PH_W),
		.waddr (i_q),
		.wdata (scr_wdata),
		.raddr (i_q),
		.rdata (scr_rdata)
	);

	assign read_wide  = 64'(dens_rdata);
	assign read_value = ctl.show_read ? read_wide[31:0] : 32'd0;
endmodule

[rtl/dgs_ctrl.sv]
// Controller state machine: command decode, pass sequencing, result strobe.
// Depends on dgs_pkg.
module dgs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         command,
	input  logic [7:0]         pass_count,
	input  dgs_pkg::dgs_stat_t stat,
	output dgs_pkg::dgs_ctl_t  ctl,
	output logic               busy,
	output logic               done,
	output logic               index_error,
	output logic               run_done
);
	import dgs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PASS  = 2'd1;
	localparam logic [1:0] ST_COPY  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [2:0] phase_q;
	logic [7:0] passes_q;
	logic       rd_q;
	logic       go;

	assign busy = state_q != ST_IDLE;
	assign go   = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_C;
			passes_q    <= '0;
			done        <= 1'b0;
			index_error <= 1'b0;
			run_done    <= 1'b0;
			rd_q        <= 1'b0;
		end else begin
			done        <= 1'b0;
			index_error <= 1'b0;
			run_done    <= 1'b0;
			rd_q        <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						case (command)
							CMD_LOAD: begin
								done        <= 1'b1;
								index_error <= stat.bad;
							end
							CMD_READ: begin
								done        <= 1'b1;
								index_error <= stat.bad;
								rd_q        <= !stat.bad;
							end
							CMD_RUN: begin
								if (pass_count == 8'd0 || !stat.grid_ok) begin
									done     <= 1'b1;
									run_done <= 1'b1;
								end else begin
									passes_q <= pass_count;
									phase_q  <= PH_C;
									state_q  <= ST_PASS;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PASS: begin
					if (phase_q == PH_W) begin
						phase_q <= PH_C;
						if (stat.last_cell) begin
							state_q <= ST_COPY;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_COPY: begin
					if (stat.last_cell) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					passes_q <= passes_q - 8'd1;
					if (passes_q == 8'd1) begin
						done     <= 1'b1;
						run_done <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						phase_q <= PH_C;
						state_q <= ST_PASS;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.host_we     = go && command == CMD_LOAD && !stat.bad;
		ctl.pass_en     = state_q == ST_PASS;
		ctl.copy_en     = state_q == ST_COPY;
		ctl.phase       = phase_q;
		ctl.sweep_clear = state_q == ST_IDLE || state_q == ST_FLUSH
			|| (state_q == ST_PASS && phase_q == PH_W && stat.last_cell);
		ctl.sweep_next  = (state_q == ST_PASS && phase_q == PH_W && !stat.last_cell)
			|| state_q == ST_COPY;
		ctl.show_read   = rd_q;
	end
endmodule
